// ===== rtl/aoc_pkg.sv =====
// Shared types and constants for the alpha-over BGRA compositing pipeline.
package aoc_pkg;

    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 3;
    localparam int PIX_W    = 32;
    localparam int WGT_W    = 16;
    localparam int NUM_W    = 24;
    localparam int DSH_W    = WGT_W + CHAN_W - 1;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    typedef struct packed {
        logic [NUM_W-1:0]  rem;
        logic [CHAN_W-1:0] quo;
    } div_lane_t;

    typedef struct packed {
        logic                       valid;
        logic                       last;
        logic                       zero;
        logic [CHAN_W-1:0]          alpha;
        logic [DSH_W-1:0]           dsh;
        div_lane_t [NUM_CHAN-1:0]   lane;
    } div_bus_t;

endpackage

// ===== rtl/aoc_div_stage.sv =====
// Two-bit restoring division step for all three color channels.
module aoc_div_stage import aoc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  div_bus_t bus_in,
    output div_bus_t bus_reg
);

    div_bus_t bus_next;

    always_comb
    begin
        logic [NUM_W-1:0] r1;
        logic [NUM_W-1:0] d_hi;
        logic [NUM_W-1:0] d_lo;
        logic             b1;
        logic             b0;
        bus_next = bus_in;
        d_hi = {1'b0, bus_in.dsh};
        d_lo = {2'b00, bus_in.dsh[DSH_W-1:1]};
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            b1 = (bus_in.lane[c].rem >= d_hi);
            r1 = b1 ? (bus_in.lane[c].rem - d_hi) : bus_in.lane[c].rem;
            b0 = (r1 >= d_lo);
            bus_next.lane[c].rem = b0 ? (r1 - d_lo) : r1;
            bus_next.lane[c].quo = {bus_in.lane[c].quo[CHAN_W-3:0], b1, b0};
        end
        bus_next.dsh = {2'b00, bus_in.dsh[DSH_W-1:2]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            bus_reg <= bus_next;
        end
    end

endmodule

// ===== rtl/alpha_over_composite_bgra_unit.sv =====
// Top level: Porter-Duff over of straight-alpha BGRA pixels, seven-stage pipeline.
//
//  channel   direction  tdata                                 tuser  tlast
//  s_axis    in         [31:0] source_pixel, [63:32] target   -      last_in
//  m_axis    out        [31:0] result_pixel                   -      last_out
//
// One pixel per clock while m_axis is not stalled; the stages are weight, products,
// numerator, then four radix-4 division steps that share nothing between pixels.
// Reset clears only the stage valid bits.
// A stall on m_axis freezes every stage at once; s_axis_tready drops only
// while the output holds a result that is not taken.
module alpha_over_composite_bgra_unit import aoc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [2*PIX_W-1:0]  s_axis_tdata,   // source_pixel, target_pixel
    input  logic                s_axis_tlast,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [PIX_W-1:0]    m_axis_tdata,   // result_pixel
    output logic                m_axis_tlast
);

    localparam int NUM_DIV = CHAN_W / 2;

    logic en;

    logic                                 v1_reg;
    logic                                 l1_reg;
    logic [CHAN_W-1:0]                    sa1_reg;
    logic [WGT_W-1:0]                     w1_reg;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]      sc1_reg;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]      tc1_reg;

    logic                                 v2_reg;
    logic                                 l2_reg;
    logic [WGT_W-1:0]                     d2_reg;
    logic [NUM_CHAN-1:0][WGT_W-1:0]       ps2_reg;
    logic [NUM_CHAN-1:0][NUM_W-1:0]       pq2_reg;

    div_bus_t                             div3_next;
    div_bus_t                             div3_reg;
    div_bus_t [NUM_DIV:0]                 chain;

    logic [CHAN_W-1:0]                    sa_in;
    logic [CHAN_W-1:0]                    ta_in;
    logic [WGT_W:0]                       d_inc;
    logic [NUM_W:0]                       a_sum;

    assign en            = !chain[NUM_DIV].valid || m_axis_tready;
    assign s_axis_tready = en;

    assign sa_in = s_axis_tdata[PIX_W-1 -: CHAN_W];
    assign ta_in = s_axis_tdata[2*PIX_W-1 -: CHAN_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l1_reg  <= s_axis_tlast;
            sa1_reg <= sa_in;
            w1_reg  <= WGT_W'(ta_in) * WGT_W'(CHAN_MAX - sa_in);
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                sc1_reg[c] <= s_axis_tdata[c*CHAN_W +: CHAN_W];
                tc1_reg[c] <= s_axis_tdata[PIX_W + c*CHAN_W +: CHAN_W];
            end
            l2_reg <= l1_reg;
            d2_reg <= ({sa1_reg, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, sa1_reg}) + w1_reg;
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                ps2_reg[c] <= WGT_W'(sa1_reg) * WGT_W'(sc1_reg[c]);
                pq2_reg[c] <= NUM_W'(w1_reg) * NUM_W'(tc1_reg[c]);
            end
        end
    end

    assign d_inc = {1'b0, d2_reg} + {{WGT_W{1'b0}}, 1'b1};
    assign a_sum = {d_inc, {CHAN_W{1'b0}}} + {{CHAN_W{1'b0}}, d_inc};

    always_comb
    begin
        div3_next       = '0;
        div3_next.valid = v2_reg;
        div3_next.last  = l2_reg;
        div3_next.zero  = (d2_reg == '0);
        div3_next.alpha = a_sum[NUM_W-1 -: CHAN_W];
        div3_next.dsh   = {d2_reg, {(CHAN_W-1){1'b0}}};
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            div3_next.lane[c].rem = ({ps2_reg[c], {CHAN_W{1'b0}}}
                                     - {{CHAN_W{1'b0}}, ps2_reg[c]}) + pq2_reg[c];
            div3_next.lane[c].quo = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div3_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            div3_reg <= div3_next;
        end
    end

    assign chain[0] = div3_reg;

    for (genvar k = 0; k < NUM_DIV; k++)
    begin : g_div
        aoc_div_stage u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .bus_in  (chain[k]),
            .bus_reg (chain[k+1])
        );
    end

    always_comb
    begin
        m_axis_tvalid = chain[NUM_DIV].valid;
        m_axis_tlast  = chain[NUM_DIV].last;
        if (chain[NUM_DIV].zero)
        begin
            m_axis_tdata = '0;
        end
        else
        begin
            m_axis_tdata = {chain[NUM_DIV].alpha, chain[NUM_DIV].lane[2].quo,
                            chain[NUM_DIV].lane[1].quo, chain[NUM_DIV].lane[0].quo};
        end
    end

endmodule

// ===== rtl/aoc_checker.sv =====
// Port-level checker for the compositing pipeline, bound to the top level.
module aoc_checker import aoc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [PIX_W-1:0]   m_axis_tdata,
    input logic               m_axis_tlast
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready does not follow output stall");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |-> m_axis_tvalid)
        else $error("request refused with empty output");

    a_reset_ready: assert property (@(posedge clk)
        !rst_n |-> s_axis_tready && !m_axis_tvalid)
        else $error("pipeline not empty in reset");

endmodule

bind alpha_over_composite_bgra_unit aoc_checker u_aoc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
